// ===== sv/lefsm_pkg.sv =====
package lefsm_pkg;

   // Widths of the channel fields.
   localparam int OP_W   = 3;
   localparam int PIN_W  = 8;
   localparam int PAGE_W = 8;
   localparam int STS_W  = 3;
   localparam int CNT_W  = 5;

   // Operation codes carried by a request beat.
   localparam logic [OP_W-1:0] OP_READ   = 3'd0;
   localparam logic [OP_W-1:0] OP_LEARN  = 3'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
   localparam logic [OP_W-1:0] OP_COUNT  = 3'd4;
   localparam logic [OP_W-1:0] OP_SET    = 3'd5;

   // Status codes returned in a response beat.
   localparam logic [STS_W-1:0] STS_NONE    = 3'd0;
   localparam logic [STS_W-1:0] STS_HIT     = 3'd1;
   localparam logic [STS_W-1:0] STS_NOMATCH = 3'd2;
   localparam logic [STS_W-1:0] STS_ADDED   = 3'd3;
   localparam logic [STS_W-1:0] STS_FULL    = 3'd4;
   localparam logic [STS_W-1:0] STS_REFUSED = 3'd5;

   // What a token asks of each cell it passes.
   localparam logic [2:0] TK_READ   = 3'd0;
   localparam logic [2:0] TK_LOOK   = 3'd1;
   localparam logic [2:0] TK_REMOVE = 3'd2;
   localparam logic [2:0] TK_CLEAR  = 3'd3;
   localparam logic [2:0] TK_COUNT  = 3'd4;
   localparam logic [2:0] TK_INSERT = 3'd5;

   // Entry pages.
   localparam logic [PAGE_W-1:0] PAGE_EMPTY  = 8'd0;
   localparam logic [PAGE_W-1:0] PAGE_GLOBAL = 8'd1;
   localparam logic [PAGE_W-1:0] PAGE_LOCAL  = 8'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

   // Control part of the token that walks down the chain of cells.
   typedef struct packed {
      logic             valid;
      logic [2:0]       kind;
      logic             found;
      logic             any;
      logic             placed;
      logic [CNT_W-1:0] cnt;
   } token_type;

endpackage

// ===== sv/lefsm_req_if.sv =====
interface lefsm_req_if;
   logic                             valid;
   logic                             ready;
   logic [lefsm_pkg::OP_W-1:0]       operation;
   logic [lefsm_pkg::PIN_W-1:0]      pin_value;
   logic [lefsm_pkg::PIN_W-1:0]      next_output;
   logic [lefsm_pkg::PAGE_W-1:0]     entry_page;

   modport source (output valid, operation, pin_value, next_output, entry_page, input ready);
   modport sink   (input valid, operation, pin_value, next_output, entry_page, output ready);
endinterface

// ===== sv/lefsm_rsp_if.sv =====
interface lefsm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lefsm_pkg::PIN_W-1:0]   output_value;
   logic [lefsm_pkg::STS_W-1:0]   status;
   logic [lefsm_pkg::CNT_W-1:0]   entry_count;

   modport source (output valid, output_value, status, entry_count, input ready);
   modport sink   (input valid, output_value, status, entry_count, output ready);
endinterface

// ===== sv/learning_edge_fsm_table_core.sv =====
// Learned edge-driven state machine. Each request beat carries an operation on
// a table of DEPTH transitions keyed by the rising and falling edges between
// the previous and the new pin word; every request yields exactly one response
// beat with the current output word, a status and, for count, the number of
// occupied entries. Read, remove, clear, count and a learn refused because an
// entry already matches make one pass over the chain of DEPTH cells before the
// response, a learn that goes on to store an entry or to find the table full
// makes two, and set output, unused codes and learns without a page or
// without an edge go straight to the response. A token enters the first cell
// and moves one cell per cycle, and a learn needs one pass to check for a
// match and a second to claim the first empty entry. One request is in flight
// at a time; a new request is taken while the previous response still waits in
// the output register. Reset empties the table at once.
module learning_edge_fsm_table_core #(
   parameter int DEPTH = 16,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   lefsm_req_if.sink        req_chan,
   lefsm_rsp_if.source      rsp_chan
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_INSERT = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Control state.
   logic [1:0]                     state_ff, state_in;
   logic                           inj_ff, inj_in;
   logic [2:0]                     kind_ff, kind_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0]               prev_ff, prev_in;
   logic [WIDTH-1:0]               cur_out_ff, cur_out_in;

   // Per-request operands and results.
   logic [WIDTH-1:0]               pin_ff, pin_in;
   logic [WIDTH-1:0]               fall_ff, fall_in, rise_ff, rise_in;
   logic [WIDTH-1:0]               nf_ff, nf_in, nr_ff, nr_in;
   logic [lefsm_pkg::PAGE_W-1:0]   pg_ff, pg_in;
   logic [lefsm_pkg::STS_W-1:0]    res_sts_ff, res_sts_in;
   logic [lefsm_pkg::CNT_W-1:0]    res_cnt_ff, res_cnt_in;

   // Response register.
   logic [lefsm_pkg::PIN_W-1:0]    rsp_out_ff, rsp_out_in;
   logic [lefsm_pkg::STS_W-1:0]    rsp_sts_ff, rsp_sts_in;
   logic [lefsm_pkg::CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;

   // Links of the chain; link k feeds cell k, link DEPTH leaves the last cell.
   lefsm_pkg::token_type           tok [0:DEPTH];
   logic [WIDTH-1:0]               fall_l [0:DEPTH];
   logic [WIDTH-1:0]               rise_l [0:DEPTH];
   logic [WIDTH-1:0]               hit_l  [0:DEPTH];

   logic [WIDTH-1:0]               req_pin, req_nxt, req_fall, req_rise;

   assign req_pin  = req_chan.pin_value[WIDTH-1:0];
   assign req_nxt  = req_chan.next_output[WIDTH-1:0];
   assign req_fall = prev_ff & ~req_pin;
   assign req_rise = req_pin & ~prev_ff;

   // The token is launched with empty results in the cycle after the request.
   always_comb begin
      tok[0]        = '0;
      tok[0].valid  = inj_ff;
      tok[0].kind   = kind_ff;
      fall_l[0]     = fall_ff;
      rise_l[0]     = rise_ff;
      hit_l[0]      = '0;
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      lefsm_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cur_out_i  (cur_out_ff),
         .prev_in_i  (prev_ff),
         .new_page_i (pg_ff),
         .new_fall_i (nf_ff),
         .new_rise_i (nr_ff),
         .tok_i      (tok[k]),
         .fall_i     (fall_l[k]),
         .rise_i     (rise_l[k]),
         .hit_i      (hit_l[k]),
         .tok_o      (tok[k+1]),
         .fall_o     (fall_l[k+1]),
         .rise_o     (rise_l[k+1]),
         .hit_o      (hit_l[k+1])
      );
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.output_value = rsp_out_ff;
   assign rsp_chan.status       = rsp_sts_ff;
   assign rsp_chan.entry_count  = rsp_cnt_ff;

   always_comb begin
      state_in     = state_ff;
      inj_in       = 1'b0;
      kind_in      = kind_ff;
      prev_in      = prev_ff;
      cur_out_in   = cur_out_ff;
      pin_in       = pin_ff;
      fall_in      = fall_ff;
      rise_in      = rise_ff;
      nf_in        = nf_ff;
      nr_in        = nr_ff;
      pg_in        = pg_ff;
      res_sts_in   = res_sts_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_out_in   = rsp_out_ff;
      rsp_sts_in   = rsp_sts_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               pin_in     = req_pin;
               fall_in    = req_fall;
               rise_in    = req_rise;
               pg_in      = req_chan.entry_page;
               nf_in      = cur_out_ff & ~req_nxt;
               nr_in      = req_nxt & ~cur_out_ff;
               res_sts_in = lefsm_pkg::STS_NONE;
               res_cnt_in = '0;
               state_in   = ST_SCAN;
               inj_in     = 1'b1;
               unique case (req_chan.operation)
                  lefsm_pkg::OP_READ:   kind_in = lefsm_pkg::TK_READ;
                  lefsm_pkg::OP_REMOVE: kind_in = lefsm_pkg::TK_REMOVE;
                  lefsm_pkg::OP_CLEAR:  kind_in = lefsm_pkg::TK_CLEAR;
                  lefsm_pkg::OP_COUNT:  kind_in = lefsm_pkg::TK_COUNT;
                  lefsm_pkg::OP_LEARN: begin
                     kind_in = lefsm_pkg::TK_LOOK;
                     // A learn without a page or without any edge does nothing.
                     if ((req_chan.entry_page == lefsm_pkg::PAGE_EMPTY) ||
                         ((req_fall | req_rise) == '0)) begin
                        inj_in   = 1'b0;
                        state_in = ST_FINISH;
                     end
                  end
                  lefsm_pkg::OP_SET: begin
                     cur_out_in = req_pin;
                     inj_in     = 1'b0;
                     state_in   = ST_FINISH;
                  end
                  default: begin
                     inj_in   = 1'b0;
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (tok[DEPTH].valid) begin
               state_in = ST_FINISH;
               unique case (kind_ff)
                  lefsm_pkg::TK_READ: begin
                     prev_in = pin_ff;
                     if (tok[DEPTH].found) begin
                        cur_out_in = hit_l[DEPTH];
                        res_sts_in = lefsm_pkg::STS_HIT;
                     end else if (tok[DEPTH].any) begin
                        res_sts_in = lefsm_pkg::STS_NOMATCH;
                     end else begin
                        res_sts_in = lefsm_pkg::STS_NONE;
                     end
                  end
                  lefsm_pkg::TK_LOOK: begin
                     if (tok[DEPTH].found) begin
                        res_sts_in = lefsm_pkg::STS_REFUSED;
                     end else begin
                        // No match anywhere: a second pass claims the first empty cell.
                        kind_in  = lefsm_pkg::TK_INSERT;
                        inj_in   = 1'b1;
                        state_in = ST_INSERT;
                     end
                  end
                  lefsm_pkg::TK_REMOVE: begin
                     res_sts_in = tok[DEPTH].found ? lefsm_pkg::STS_HIT
                                                   : lefsm_pkg::STS_NOMATCH;
                  end
                  lefsm_pkg::TK_CLEAR: begin
                     cur_out_in = '0;
                     res_sts_in = tok[DEPTH].any ? lefsm_pkg::STS_HIT : lefsm_pkg::STS_NONE;
                  end
                  lefsm_pkg::TK_COUNT: begin
                     res_cnt_in = tok[DEPTH].cnt;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_INSERT: begin
            if (tok[DEPTH].valid) begin
               res_sts_in = tok[DEPTH].placed ? lefsm_pkg::STS_ADDED : lefsm_pkg::STS_FULL;
               state_in   = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // The output register frees up in the same cycle that its beat is taken.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_out_in   = lefsm_pkg::PIN_W'(cur_out_ff);
               rsp_sts_in   = res_sts_ff;
               rsp_cnt_in   = res_cnt_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         inj_ff       <= 1'b0;
         kind_ff      <= lefsm_pkg::TK_READ;
         rsp_valid_ff <= 1'b0;
         prev_ff      <= '0;
         cur_out_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         inj_ff       <= inj_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
         prev_ff      <= prev_in;
         cur_out_ff   <= cur_out_in;
      end
   end

   always_ff @(posedge clock) begin
      pin_ff     <= pin_in;
      fall_ff    <= fall_in;
      rise_ff    <= rise_in;
      nf_ff      <= nf_in;
      nr_ff      <= nr_in;
      pg_ff      <= pg_in;
      res_sts_ff <= res_sts_in;
      res_cnt_ff <= res_cnt_in;
      rsp_out_ff <= rsp_out_in;
      rsp_sts_ff <= rsp_sts_in;
      rsp_cnt_ff <= rsp_cnt_in;
   end

endmodule

// ===== sv/lefsm_cell.sv =====
// One table entry. A token passing through is examined against the entry and
// handed on to the next cell through a register, in the cycle after.
module lefsm_cell #(
   parameter int WIDTH = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [WIDTH-1:0]              cur_out_i,
   input  logic [WIDTH-1:0]              prev_in_i,
   input  logic [lefsm_pkg::PAGE_W-1:0]  new_page_i,
   input  logic [WIDTH-1:0]              new_fall_i,
   input  logic [WIDTH-1:0]              new_rise_i,
   input  lefsm_pkg::token_type          tok_i,
   input  logic [WIDTH-1:0]              fall_i,
   input  logic [WIDTH-1:0]              rise_i,
   input  logic [WIDTH-1:0]              hit_i,
   output lefsm_pkg::token_type          tok_o,
   output logic [WIDTH-1:0]              fall_o,
   output logic [WIDTH-1:0]              rise_o,
   output logic [WIDTH-1:0]              hit_o
);

   logic [lefsm_pkg::PAGE_W-1:0] page_ff, page_in;
   logic [WIDTH-1:0]             fb_ff, inp_ff, in_fall_ff, in_rise_ff, out_fall_ff, out_rise_ff;
   lefsm_pkg::token_type         tok_ff, tok_in;
   logic [WIDTH-1:0]             fall_ff, rise_ff, hit_ff, hit_in;
   logic                         occupied, match, wr_en;

   assign occupied = (page_ff != lefsm_pkg::PAGE_EMPTY);
   assign match = occupied && (in_fall_ff == fall_i) && (in_rise_ff == rise_i) &&
                  ((page_ff == lefsm_pkg::PAGE_GLOBAL) ||
                   ((fb_ff == cur_out_i) &&
                    ((page_ff == lefsm_pkg::PAGE_LOCAL) || (inp_ff == prev_in_i))));

   always_comb begin
      tok_in  = tok_i;
      hit_in  = hit_i;
      page_in = page_ff;
      wr_en   = 1'b0;
      if (tok_i.valid) begin
         if (occupied) begin
            tok_in.any = 1'b1;
            if (tok_i.cnt != lefsm_pkg::CNT_MAX) begin
               tok_in.cnt = tok_i.cnt + 5'd1;
            end
         end
         unique case (tok_i.kind)
            lefsm_pkg::TK_READ: begin
               if (!tok_i.found && match) begin
                  tok_in.found = 1'b1;
                  hit_in = (fb_ff | out_rise_ff) & ~out_fall_ff;
               end
            end
            lefsm_pkg::TK_LOOK: begin
               if (!tok_i.found && match) begin
                  tok_in.found = 1'b1;
               end
            end
            lefsm_pkg::TK_REMOVE: begin
               if (!tok_i.found && match) begin
                  tok_in.found = 1'b1;
                  page_in = lefsm_pkg::PAGE_EMPTY;
               end
            end
            lefsm_pkg::TK_INSERT: begin
               if (!tok_i.placed && !occupied) begin
                  tok_in.placed = 1'b1;
                  page_in = new_page_i;
                  wr_en = 1'b1;
               end
            end
            lefsm_pkg::TK_CLEAR: begin
               page_in = lefsm_pkg::PAGE_EMPTY;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         page_ff <= lefsm_pkg::PAGE_EMPTY;
         tok_ff  <= '0;
      end else begin
         page_ff <= page_in;
         tok_ff  <= tok_in;
      end
   end

   always_ff @(posedge clock) begin
      fall_ff <= fall_i;
      rise_ff <= rise_i;
      hit_ff  <= hit_in;
      if (wr_en) begin
         fb_ff       <= cur_out_i;
         inp_ff      <= prev_in_i;
         in_fall_ff  <= fall_i;
         in_rise_ff  <= rise_i;
         out_fall_ff <= new_fall_i;
         out_rise_ff <= new_rise_i;
      end
   end

   assign tok_o  = tok_ff;
   assign fall_o = fall_ff;
   assign rise_o = rise_ff;
   assign hit_o  = hit_ff;

endmodule
